/* rtl/tagged_mailbox_queue_macros.svh */
// Assertion helpers for the mailbox queue checker.
`ifndef TAGGED_MAILBOX_QUEUE_MACROS_SVH
`define TAGGED_MAILBOX_QUEUE_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TMQ_ASSERT(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (prop)) else $error(msg);

// Condition must never be seen at a clock edge outside reset.
`define TMQ_ASSERT_NEVER(lbl, clk, rstn, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) !(cond)) else $error(msg);

`endif

/* rtl/tmq_pkg.sv */
`default_nettype none

package tmq_pkg;

  localparam int unsigned DefaultQueueDepth = 16;
  localparam int unsigned TagW  = 32;
  localparam int unsigned DataW = 32;
  localparam int unsigned OccW  = 5;

  localparam logic CmdSend = 1'b0;
  localparam logic CmdRead = 1'b1;

  typedef struct packed {
    logic             cmd;
    logic [TagW-1:0]  recipient_tag;
    logic [DataW-1:0] msg_data;
    logic [TagW-1:0]  requester_tag;
  } req_t;

  typedef struct packed {
    logic [DataW-1:0] read_data;
    logic             found;
    logic             dropped;
    logic [OccW-1:0]  occupancy;
  } rsp_t;

  typedef struct packed {
    logic [TagW-1:0]  tag;
    logic [DataW-1:0] data;
  } entry_t;

endpackage

`default_nettype wire

/* rtl/tmq_if.sv */
`default_nettype none

interface tmq_in_if;
  import tmq_pkg::*;

  logic             valid;
  logic             ready;
  logic             cmd;
  logic [TagW-1:0]  recipient_tag;
  logic [DataW-1:0] msg_data;
  logic [TagW-1:0]  requester_tag;

  modport source (output valid, output cmd, output recipient_tag, output msg_data,
                  output requester_tag, input ready);
  modport sink   (input valid, input cmd, input recipient_tag, input msg_data,
                  input requester_tag, output ready);
endinterface

interface tmq_out_if;
  import tmq_pkg::*;

  logic             valid;
  logic             ready;
  logic [DataW-1:0] read_data;
  logic             found;
  logic             dropped;
  logic [OccW-1:0]  occupancy;

  modport source (output valid, output read_data, output found, output dropped,
                  output occupancy, input ready);
  modport sink   (input valid, input read_data, input found, input dropped,
                  input occupancy, output ready);
endinterface

`default_nettype wire

/* rtl/tmq_mem.sv */
`default_nettype none

module tmq_mem #(
  parameter int unsigned Depth = tmq_pkg::DefaultQueueDepth
) (
  input  logic                     clk_i,
  input  logic                     rd_en_i,
  input  logic [$clog2(Depth)-1:0] rd_addr_i,
  output tmq_pkg::entry_t          rd_entry_o,
  input  logic                     wr_en_i,
  input  logic [$clog2(Depth)-1:0] wr_addr_i,
  input  tmq_pkg::entry_t          wr_entry_i
);
  import tmq_pkg::*;

  logic [TagW-1:0]  tag_mem  [Depth];
  logic [DataW-1:0] data_mem [Depth];
  entry_t           rd_entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      tag_mem[wr_addr_i]  <= wr_entry_i.tag;
      data_mem[wr_addr_i] <= wr_entry_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_entry_q.tag  <= tag_mem[rd_addr_i];
      rd_entry_q.data <= data_mem[rd_addr_i];
    end
  end

  assign rd_entry_o = rd_entry_q;

endmodule

`default_nettype wire

/* rtl/tmq_ctrl.sv */
`default_nettype none

module tmq_ctrl #(
  parameter int unsigned QueueDepth = tmq_pkg::DefaultQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          req_valid_i,
  output logic                          req_ready_o,
  input  tmq_pkg::req_t                 req_i,
  output logic                          rsp_valid_o,
  input  logic                          rsp_ready_i,
  output tmq_pkg::rsp_t                 rsp_o,
  output logic                          rd_en_o,
  output logic [$clog2(QueueDepth)-1:0] rd_addr_o,
  input  tmq_pkg::entry_t               rd_entry_i,
  output logic                          wr_en_o,
  output logic [$clog2(QueueDepth)-1:0] wr_addr_o,
  output tmq_pkg::entry_t               wr_entry_o
);
  import tmq_pkg::*;

  localparam int unsigned AW = $clog2(QueueDepth);
  localparam int unsigned CW = $clog2(QueueDepth + 1);
  localparam logic [CW-1:0] Full = CW'(QueueDepth);

  localparam logic [2:0] StIdle    = 3'd0;
  localparam logic [2:0] StScanRd  = 3'd1;
  localparam logic [2:0] StScanCmp = 3'd2;
  localparam logic [2:0] StShiftRd = 3'd3;
  localparam logic [2:0] StShiftWr = 3'd4;
  localparam logic [2:0] StResp    = 3'd5;

  logic [2:0]       state_q, state_d;
  logic [AW-1:0]    idx_q, idx_d;
  logic [CW-1:0]    fill_q, fill_d;
  logic [TagW-1:0]  qtag_q, qtag_d;
  logic [DataW-1:0] rdata_q, rdata_d;
  logic             found_q, found_d;
  logic             dropped_q, dropped_d;
  logic [CW-1:0]    idx_nx1, idx_nx2;

  assign idx_nx1 = CW'(idx_q) + CW'(1);
  assign idx_nx2 = idx_nx1 + CW'(1);

  always_comb begin
    state_d     = state_q;
    idx_d       = idx_q;
    fill_d      = fill_q;
    qtag_d      = qtag_q;
    rdata_d     = rdata_q;
    found_d     = found_q;
    dropped_d   = dropped_q;
    req_ready_o = 1'b0;
    rsp_valid_o = 1'b0;
    rd_en_o     = 1'b0;
    rd_addr_o   = idx_q;
    wr_en_o     = 1'b0;
    wr_addr_o   = idx_q;
    wr_entry_o  = rd_entry_i;

    unique case (state_q)
      StIdle: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          rdata_d   = '0;
          found_d   = 1'b0;
          dropped_d = 1'b0;
          if (req_i.cmd == CmdRead) begin
            qtag_d  = req_i.requester_tag;
            idx_d   = '0;
            state_d = (fill_q == '0) ? StResp : StScanRd;
          end else begin
            wr_addr_o       = AW'(fill_q);
            wr_entry_o.tag  = req_i.recipient_tag;
            wr_entry_o.data = req_i.msg_data;
            if (fill_q == Full) begin
              dropped_d = 1'b1;
            end else begin
              wr_en_o = 1'b1;
              fill_d  = fill_q + CW'(1);
            end
            state_d = StResp;
          end
        end
      end
      StScanRd: begin
        rd_en_o = 1'b1;
        state_d = StScanCmp;
      end
      StScanCmp: begin
        if (rd_entry_i.tag == qtag_q) begin
          rdata_d = rd_entry_i.data;
          found_d = 1'b1;
          if (idx_nx1 < fill_q) begin
            state_d = StShiftRd;
          end else begin
            fill_d  = fill_q - CW'(1);
            state_d = StResp;
          end
        end else if (idx_nx1 < fill_q) begin
          idx_d   = idx_q + AW'(1);
          state_d = StScanRd;
        end else begin
          state_d = StResp;
        end
      end
      StShiftRd: begin
        rd_en_o   = 1'b1;
        rd_addr_o = AW'(idx_nx1);
        state_d   = StShiftWr;
      end
      StShiftWr: begin
        wr_en_o = 1'b1;
        idx_d   = idx_q + AW'(1);
        if (idx_nx2 < fill_q) begin
          state_d = StShiftRd;
        end else begin
          fill_d  = fill_q - CW'(1);
          state_d = StResp;
        end
      end
      StResp: begin
        rsp_valid_o = 1'b1;
        if (rsp_ready_i) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_comb begin
    rsp_o.read_data = rdata_q;
    rsp_o.found     = found_q;
    rsp_o.dropped   = dropped_q;
    rsp_o.occupancy = OccW'(fill_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      fill_q  <= '0;
    end else begin
      state_q <= state_d;
      fill_q  <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    idx_q     <= idx_d;
    qtag_q    <= qtag_d;
    rdata_q   <= rdata_d;
    found_q   <= found_d;
    dropped_q <= dropped_d;
  end

endmodule

`default_nettype wire

/* rtl/tagged_mailbox_queue.sv */
// Tagged mailbox queue: up to QUEUE_DEPTH messages kept in arrival order.
// Input channel in_ch_i carries one request per transfer: cmd selects a send
// (store recipient_tag and msg_data at the tail) or a read (find the oldest
// entry whose tag equals requester_tag, return its data and close the gap).
// Output channel out_ch_o returns exactly one result per request with
// read_data, found, dropped and the occupancy after the operation.
// Entries live in one single-port-read, single-port-write memory with a
// registered read; the sequencer touches it one entry at a time.
// A send writes the tail entry when the request is taken, unless the queue is
// full; a read scans the entries from the oldest, a memory read and then a tag
// compare per entry, up to the match, then moves each later entry down by one
// read and one write. A new request is taken in the cycle after the result has
// moved to the output register.
// Read and write never address the same entry in one cycle.
// Reset clears the fill count, the sequencer and the output valid flag; the
// memory is not cleared, only filled entries are ever read.
// When the receiver stalls, the result holds in the output register; one more
// request can be processed behind it and then waits for the register to free.
`default_nettype none

module tagged_mailbox_queue #(
  parameter int unsigned QUEUE_DEPTH = tmq_pkg::DefaultQueueDepth
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  tmq_in_if.sink           in_ch_i,
  tmq_out_if.source        out_ch_o
);
  import tmq_pkg::*;

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);

  req_t          req;
  rsp_t          rsp;
  logic          rsp_valid;
  logic          rsp_ready;
  logic          rd_en;
  logic [AW-1:0] rd_addr;
  entry_t        rd_entry;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  entry_t        wr_entry;
  logic          out_valid_q;
  rsp_t          out_q;

  always_comb begin
    req.cmd           = in_ch_i.cmd;
    req.recipient_tag = in_ch_i.recipient_tag;
    req.msg_data      = in_ch_i.msg_data;
    req.requester_tag = in_ch_i.requester_tag;
  end

  tmq_ctrl #(
    .QueueDepth(QUEUE_DEPTH)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .req_valid_i(in_ch_i.valid),
    .req_ready_o(in_ch_i.ready),
    .req_i      (req),
    .rsp_valid_o(rsp_valid),
    .rsp_ready_i(rsp_ready),
    .rsp_o      (rsp),
    .rd_en_o    (rd_en),
    .rd_addr_o  (rd_addr),
    .rd_entry_i (rd_entry),
    .wr_en_o    (wr_en),
    .wr_addr_o  (wr_addr),
    .wr_entry_o (wr_entry)
  );

  tmq_mem #(
    .Depth(QUEUE_DEPTH)
  ) u_mem (
    .clk_i     (clk_i),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_entry_o(rd_entry),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_entry_i(wr_entry)
  );

  assign rsp_ready = !out_valid_q || out_ch_o.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (rsp_ready) begin
      out_valid_q <= rsp_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rsp_ready && rsp_valid) begin
      out_q <= rsp;
    end
  end

  assign out_ch_o.valid     = out_valid_q;
  assign out_ch_o.read_data = out_q.read_data;
  assign out_ch_o.found     = out_q.found;
  assign out_ch_o.dropped   = out_q.dropped;
  assign out_ch_o.occupancy = out_q.occupancy;

endmodule

`default_nettype wire

/* rtl/tmq_checker.sv */
`default_nettype none

`include "tagged_mailbox_queue_macros.svh"

module tmq_checker (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [4:0] out_occupancy_i
);

  logic [2:0] pending_q;
  logic       in_xfer;
  logic       out_xfer;

  assign in_xfer  = in_valid_i && in_ready_i;
  assign out_xfer = out_valid_i && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(in_xfer) - 3'(out_xfer);
    end
  end

  `TMQ_ASSERT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_occupancy_i), "result changed while stalled")
  `TMQ_ASSERT_NEVER(a_no_invented, clk_i, rst_ni, out_valid_i && (pending_q == 3'd0), "result without request")
  `TMQ_ASSERT_NEVER(a_bounded, clk_i, rst_ni, pending_q > 3'd2, "too many requests in flight")

endmodule

bind tagged_mailbox_queue tmq_checker u_tmq_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid_i     (in_ch_i.valid),
  .in_ready_i     (in_ch_i.ready),
  .out_valid_i    (out_ch_o.valid),
  .out_ready_i    (out_ch_o.ready),
  .out_occupancy_i(out_ch_o.occupancy)
);

`default_nettype wire

/* verif/tb.sv */
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmq_pkg::*;

  localparam int unsigned Depth = DefaultQueueDepth;
  localparam int unsigned ItemsPerPhase = 185;

  logic clk_i = 1'b0;
  logic rst_ni;

  tmq_in_if  in_ch ();
  tmq_out_if out_ch ();

  tagged_mailbox_queue #(
    .QUEUE_DEPTH(Depth)
  ) u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_ch_i (in_ch),
    .out_ch_o(out_ch)
  );

  always #4 clk_i = ~clk_i;

  req_t        request_q[$];
  rsp_t        expected_rsp_q[$];
  entry_t      mailbox_store[$];
  logic [31:0] tag_pool[6];
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned mismatch_count;

  function automatic rsp_t apply_to_mailbox(req_t req);
    rsp_t   rsp;
    entry_t slot;
    int     hit;
    rsp = '0;
    hit = -1;
    if (req.cmd == CmdSend) begin
      if (mailbox_store.size() < Depth) begin
        slot.tag  = req.recipient_tag;
        slot.data = req.msg_data;
        mailbox_store.push_back(slot);
      end else begin
        rsp.dropped = 1'b1;
      end
    end else begin
      for (int i = 0; i < mailbox_store.size(); i++) begin
        if (hit < 0 && mailbox_store[i].tag == req.requester_tag) begin
          hit = i;
        end
      end
      if (hit >= 0) begin
        rsp.read_data = mailbox_store[hit].data;
        rsp.found     = 1'b1;
        mailbox_store.delete(hit);
      end
    end
    rsp.occupancy = OccW'(mailbox_store.size());
    return rsp;
  endfunction

  function automatic req_t make_req(logic cmd, logic [31:0] rtag, logic [31:0] data,
                                    logic [31:0] qtag);
    req_t req;
    req.cmd           = cmd;
    req.recipient_tag = rtag;
    req.msg_data      = data;
    req.requester_tag = qtag;
    return req;
  endfunction

  function automatic logic [31:0] pick_tag();
    if ($urandom_range(99) < 90) begin
      return tag_pool[$urandom_range(5)];
    end
    return $urandom;
  endfunction

  function automatic req_t random_req(int unsigned send_pct);
    logic cmd;
    cmd = ($urandom_range(99) < send_pct) ? CmdSend : CmdRead;
    return make_req(cmd, pick_tag(), $urandom, pick_tag());
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    $display("mismatch %s: got %0h, expected %0h at %0t", what, got, want, $time);
    mismatch_count++;
  endtask

  task automatic wait_until_drained();
    do begin
      @(negedge clk_i);
    end while (request_q.size() != 0 || in_ch.valid || expected_rsp_q.size() != 0);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : drive_requests
    req_t next_req;
    if (!rst_ni) begin
      in_ch.valid         <= 1'b0;
      in_ch.cmd           <= CmdSend;
      in_ch.recipient_tag <= '0;
      in_ch.msg_data      <= '0;
      in_ch.requester_tag <= '0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_rsp_q.push_back(apply_to_mailbox(make_req(in_ch.cmd, in_ch.recipient_tag,
                                                           in_ch.msg_data,
                                                           in_ch.requester_tag)));
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (request_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          next_req = request_q.pop_front();
          in_ch.valid         <= 1'b1;
          in_ch.cmd           <= next_req.cmd;
          in_ch.recipient_tag <= next_req.recipient_tag;
          in_ch.msg_data      <= next_req.msg_data;
          in_ch.requester_tag <= next_req.requester_tag;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : check_results
    rsp_t want;
    if (!rst_ni) begin
      out_ch.ready <= 1'b0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (expected_rsp_q.size() == 0) begin
          report_mismatch("unexpected transfer, read_data", out_ch.read_data, '0);
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_ch.read_data !== want.read_data)
            report_mismatch("read_data", out_ch.read_data, want.read_data);
          if (out_ch.found !== want.found)
            report_mismatch("found", 32'(out_ch.found), 32'(want.found));
          if (out_ch.dropped !== want.dropped)
            report_mismatch("dropped", 32'(out_ch.dropped), 32'(want.dropped));
          if (out_ch.occupancy !== want.occupancy)
            report_mismatch("occupancy", 32'(out_ch.occupancy), 32'(want.occupancy));
        end
      end
      out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  initial begin : stimulus
    int unsigned send_pct;
    rst_ni              = 1'b0;
    in_ch.valid         = 1'b0;
    in_ch.cmd           = CmdSend;
    in_ch.recipient_tag = '0;
    in_ch.msg_data      = '0;
    in_ch.requester_tag = '0;
    out_ch.ready        = 1'b0;
    send_idle_pct       = 0;
    recv_stall_pct      = 0;
    mismatch_count      = 0;
    send_pct            = 50;
    tag_pool[0] = 32'h0000_0000;
    tag_pool[1] = 32'hFFFF_FFFF;
    for (int i = 2; i < 6; i++) tag_pool[i] = $urandom;
    repeat (4) @(posedge clk_i);
    rst_ni = 1'b1;

    // read of an empty store, extremes, a miss, then fill past full
    request_q.push_back(make_req(CmdRead, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    request_q.push_back(make_req(CmdSend, 32'h0, 32'h0, 32'hFFFF_FFFF));
    request_q.push_back(make_req(CmdSend, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    request_q.push_back(make_req(CmdRead, 32'h0, 32'h0, 32'h1234_5678));
    request_q.push_back(make_req(CmdRead, 32'h0, 32'h0, 32'hFFFF_FFFF));
    for (int i = 0; i < 15; i++) begin
      request_q.push_back(make_req(CmdSend, (i % 2) ? 32'h9 : 32'h7, 32'h100 + i, $urandom));
    end
    request_q.push_back(make_req(CmdSend, 32'h9, 32'hDEAD_BEEF, 32'h9));
    request_q.push_back(make_req(CmdRead, 32'h7, 32'h0, 32'h9));
    request_q.push_back(make_req(CmdRead, 32'h0, 32'h0, 32'h0));
    request_q.push_back(make_req(CmdRead, $urandom, $urandom, 32'h7));
    wait_until_drained();

    for (int phase = 0; phase < 4; phase++) begin
      case (phase)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 52; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 52; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      for (int n = 0; n < ItemsPerPhase; n++) begin
        if (n % 30 == 0) begin
          case ($urandom_range(2))
            0: send_pct = 25;
            1: send_pct = 50;
            default: send_pct = 85;
          endcase
        end
        request_q.push_back(random_req(send_pct));
      end
      wait_until_drained();
    end

    repeat (40) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("PASS tagged_mailbox_queue");
    end else begin
      $display("FAIL tagged_mailbox_queue");
    end
    $finish;
  end

  initial begin : watchdog
    #5_000_000;
    $display("FAIL tagged_mailbox_queue");
    $finish;
  end

endmodule
